>>> design/bbc_pkg.sv
// Shared types, sizes and step functions for the binary / packed-BCD converter.
// Used by bbc_front, bbc_stage and binary_bcd_converter; depends on nothing.
package bbc_pkg;

  localparam int BCD_DIGITS = 8;
  localparam int NSTAGE     = 4;

  localparam longint unsigned BCD_LIMIT = 64'd10 ** BCD_DIGITS;

  localparam int NIB_MAX = (BCD_DIGITS < 8) ? BCD_DIGITS : 8;
  localparam int BCD_W   = 4 * NIB_MAX;

  localparam int BIN_W     = (BCD_LIMIT > 64'h8000_0000) ? 31 : $clog2(BCD_LIMIT);
  localparam int BIN_STEPS = (BIN_W + NSTAGE - 1) / NSTAGE;
  localparam int BIN_PW    = BIN_STEPS * NSTAGE;

  localparam int HOR_STEPS = (NIB_MAX + NSTAGE - 1) / NSTAGE;
  localparam int HOR_PW    = 4 * HOR_STEPS * NSTAGE;

  localparam longint unsigned REPUNIT = (64'd10 ** NIB_MAX - 64'd1) / 64'd9;
  localparam int ACC_W = $clog2(64'd15 * REPUNIT + 64'd1);

  localparam logic [5:0] BITS_CAP = 6'(4 * NIB_MAX);

  typedef struct packed {
    logic              act;
    logic              oor;
    logic [BCD_W-1:0]  mask;
    logic [BIN_PW-1:0] bin;
    logic [BCD_W-1:0]  bcd;
    logic [HOR_PW-1:0] digits;
    logic [ACC_W-1:0]  acc;
  } bbc_work_t;

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] d, input logic b);
    logic [BCD_W-1:0] t;
    t = d;
    for (int i = 0; i < NIB_MAX; i++) begin
      if (t[4*i +: 4] >= 4'd5) begin
        t[4*i +: 4] = t[4*i +: 4] + 4'd3;
      end
    end
    return {t[BCD_W-2:0], b};
  endfunction

  function automatic logic [ACC_W-1:0] horner(input logic [ACC_W-1:0] acc,
                                              input logic [3:0] nib);
    logic [ACC_W-1:0] x8;
    logic [ACC_W-1:0] x2;
    x8 = acc << 3;
    x2 = acc << 1;
    return x8 + x2 + ACC_W'(nib);
  endfunction

  function automatic logic bcd_ok(input logic [BCD_W-1:0] d);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < NIB_MAX; i++) begin
      if (d[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

>>> design/bbc_front.sv
// Request decode: range check, sign handling, nibble mask and source words.
// Depends on bbc_pkg.
module bbc_front import bbc_pkg::*; (
  input  logic               action,
  input  logic signed [31:0] value,
  input  logic [5:0]         nbits,
  output bbc_work_t          work
);

  logic [5:0]  bits_c;
  logic [31:0] mask32;
  logic [63:0] vext;
  logic        oor;
  logic        bin_ok;

  always_comb begin
    bits_c = (nbits > 6'd32) ? 6'd32 : nbits;
    if (bits_c > BITS_CAP) begin
      bits_c = BITS_CAP;
    end
    mask32 = (bits_c >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << bits_c) - 32'd1);
    vext   = {32'd0, value[31:0]};
    oor    = !action && !value[31] && (vext >= BCD_LIMIT);
    bin_ok = !action && !value[31] && !oor;

    work.act    = action;
    work.oor    = oor;
    work.mask   = mask32[BCD_W-1:0];
    work.bin    = bin_ok ? BIN_PW'(value[BIN_W-1:0]) : '0;
    work.bcd    = '0;
    work.digits = action ? HOR_PW'(value[BCD_W-1:0] & mask32[BCD_W-1:0]) : '0;
    work.acc    = '0;
  end

endmodule

>>> design/bbc_stage.sv
// One pipeline stage: a slice of double-dabble shifts and Horner digit steps,
// with its own valid bit and stall-aware load. Depends on bbc_pkg.
module bbc_stage import bbc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  input  bbc_work_t up_data,
  output logic      up_ready,
  output logic      valid,
  output bbc_work_t data,
  input  logic      dn_ready
);

  bbc_work_t data_next;

  always_comb begin
    data_next = up_data;
    for (int s = 0; s < BIN_STEPS; s++) begin
      data_next.bcd = dabble(data_next.bcd, data_next.bin[BIN_PW-1]);
      data_next.bin = data_next.bin << 1;
    end
    for (int s = 0; s < HOR_STEPS; s++) begin
      data_next.acc    = horner(data_next.acc, data_next.digits[HOR_PW-1 -: 4]);
      data_next.digits = data_next.digits << 4;
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

>>> design/binary_bcd_converter.sv
// Binary / packed-BCD converter, top level: request decode, stage chain, result.
// Depends on bbc_pkg, bbc_front and bbc_stage.
//
// Request channel: req_valid / req_stall with action, value, nbits.
// action 0 turns a signed binary value into packed BCD digits (units digit
// lowest), kept to the low nbits bits; a value of 10^8 or more gives all ones
// and out_of_range, a negative value gives zero. action 1 reads the low nbits
// bits of value as BCD nibbles and returns the binary value of those digits.
// Result channel: res_valid / res_stall with result, out_of_range.
// A request passes through the stage chain, one register per stage; each
// stage runs seven double-dabble shifts and two Horner digit steps.
// Throughput is one request per cycle while req_stall stays low.
// Reset clears all stage valid bits; the chain is empty afterwards.
// When the receiver stalls, the last stage holds its result and the stall
// backs up through the chain; req_stall rises only when every stage is full.
module binary_bcd_converter import bbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               action,
  input  logic signed [31:0] value,
  input  logic [5:0]         nbits,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [31:0]        result,
  output logic               out_of_range
);

  bbc_work_t            front_work;
  bbc_work_t            sdata [NSTAGE];
  logic [NSTAGE-1:0]    svalid;
  logic [NSTAGE-1:0]    sready;
  bbc_work_t            last;

  bbc_front u_front (
    .action (action),
    .value  (value),
    .nbits  (nbits),
    .work   (front_work)
  );

  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    bbc_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid ((g == 0) ? req_valid : svalid[(g == 0) ? 0 : g-1]),
      .up_data  ((g == 0) ? front_work : sdata[(g == 0) ? 0 : g-1]),
      .up_ready (sready[g]),
      .valid    (svalid[g]),
      .data     (sdata[g]),
      .dn_ready ((g == NSTAGE-1) ? !res_stall : sready[(g == NSTAGE-1) ? g : g+1])
    );
  end

  assign last         = sdata[NSTAGE-1];
  assign req_stall    = !sready[0];
  assign res_valid    = svalid[NSTAGE-1];
  assign out_of_range = last.oor;
  assign result       = last.oor ? 32'hFFFF_FFFF :
                        last.act ? 32'(last.acc) : 32'(last.bcd & last.mask);

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (&svalid))
    else $error("request stalled while a stage is empty");

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last.act && !last.oor |-> bcd_ok(last.bcd))
    else $error("BCD digit above nine after conversion");

  a_oor_only_bin: assert property (@(posedge clk) disable iff (rst)
    res_valid && last.act |-> !out_of_range)
    else $error("out_of_range set on BCD to binary request");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
`endif

endmodule
